FILE: rtl/ft12_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// FT1.2 frame receiver assertion macros
// Shorthand for the concurrent checks of the receiver top level.
// ----------------------------------------------------------------------------
`ifndef FT12_FRAME_RECEIVER_ASSERT_SVH
`define FT12_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, off during reset
`define FT12_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ft12 check failed: same-cycle implication");

// next-cycle implication, off during reset
`define FT12_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ft12 check failed: next-cycle implication");

`endif

FILE: rtl/ft12_pkg.sv
// ----------------------------------------------------------------------------
// FT1.2 receiver package
// Shared types, codes and constants of the FT1.2 frame receiver.
// ----------------------------------------------------------------------------
package ft12_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_STATION_ADDR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADDR_BYTES   = 2'd1;

  localparam logic [15:0] STATION_ADDR_RST = 16'h0001;
  localparam logic [1:0]  ADDR_BYTES_RST   = 2'd1;

  localparam logic [7:0] START_LONG  = 8'h68;
  localparam logic [7:0] START_SHORT = 8'h10;
  localparam logic [7:0] END_BYTE    = 8'h16;
  localparam logic [7:0] SINGLE_ACK  = 8'hE5;
  localparam logic [3:0] FUNC_MASK   = 4'hF;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_S_CTRL,
    PH_S_ADDR,
    PH_S_SUM,
    PH_S_END,
    PH_L_LEN1,
    PH_L_LEN2,
    PH_L_START,
    PH_L_CTRL,
    PH_L_ADDR,
    PH_L_DATA,
    PH_L_SUM,
    PH_L_END
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_SINGLE    = 3'd1,
    KIND_SHORT_OK  = 3'd2,
    KIND_LONG_OK   = 3'd3,
    KIND_SUM_ERR   = 3'd4,
    KIND_FRAME_ERR = 3'd5,
    KIND_OTHER_STN = 3'd6
  } kind_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] ctrl;
    logic [7:0] user_length;
  } result_t;

endpackage

FILE: rtl/ft12_in_stage.sv
// ----------------------------------------------------------------------------
// FT1.2 input stage
// Holds one accepted input beat until the parser consumes it.
// ----------------------------------------------------------------------------
module ft12_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            op,
  input  logic [7:0]      rx_byte,
  input  logic            advance,
  output logic            item_valid,
  output ft12_pkg::item_t item
);

  logic            held;
  ft12_pkg::item_t item_q;

  // slot frees in the same cycle the parser takes the held beat
  assign in_ready   = !held || advance;
  assign item_valid = held;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.op      <= op;
      item_q.rx_byte <= rx_byte;
    end
  end

endmodule

FILE: rtl/ft12_parser.sv
// ----------------------------------------------------------------------------
// FT1.2 frame parser
// Frame state machine with sum and address collection; one byte per beat.
// ----------------------------------------------------------------------------
module ft12_parser (
  input  logic              clk,
  input  logic              rst,
  input  ft12_pkg::item_t   item,
  input  logic              advance,
  input  logic [15:0]       station_address,
  input  logic [1:0]        address_bytes,
  output logic              res_emit,
  output ft12_pkg::result_t res
);

  ft12_pkg::phase_t phase, phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  control_byte, control_byte_next;
  logic [15:0] address_value, address_value_next;

  logic [7:0]       b;
  logic             is_idle;
  logic [1:0]       nab;
  logic [2:0]       nab_plus1;
  logic [7:0]       count_inc;
  logic             too_short;
  logic [7:0]       long_ulen;
  ft12_pkg::phase_t hunt_phase;

  assign b         = item.rx_byte;
  assign is_idle   = (item.op == ft12_pkg::OP_IDLE);
  assign nab       = address_bytes[1] ? 2'd2 : 2'd1;
  assign nab_plus1 = {1'b0, nab} + 3'd1;
  assign count_inc = byte_count + 8'd1;
  assign too_short = frame_length < {5'b0, nab_plus1};
  assign long_ulen = frame_length - {5'b0, nab_plus1};

  always_comb begin
    if (b == ft12_pkg::START_SHORT) begin
      hunt_phase = ft12_pkg::PH_S_CTRL;
    end else if (b == ft12_pkg::START_LONG) begin
      hunt_phase = ft12_pkg::PH_L_LEN1;
    end else begin
      hunt_phase = ft12_pkg::PH_HUNT;
    end
  end

  // closing status: sum is checked before the address
  function automatic ft12_pkg::result_t closing(input logic [7:0]    sum,
                                                input logic [15:0]   addr,
                                                input logic [15:0]   stn,
                                                input logic [7:0]    ctrl,
                                                input ft12_pkg::kind_t ok_kind,
                                                input logic [7:0]    ulen);
    ft12_pkg::result_t r;
    r = '0;
    if (sum != 8'd0) begin
      r.kind = ft12_pkg::KIND_SUM_ERR;
    end else if (addr != stn) begin
      r.kind = ft12_pkg::KIND_OTHER_STN;
    end else begin
      r.kind        = ok_kind;
      r.ctrl        = ctrl;
      r.user_length = ulen;
    end
    return r;
  endfunction

  // next phase
  always_comb begin
    phase_next = phase;
    if (is_idle) begin
      phase_next = ft12_pkg::PH_HUNT;
    end else begin
      unique case (phase)
        ft12_pkg::PH_HUNT:    phase_next = hunt_phase;
        ft12_pkg::PH_S_CTRL:  phase_next = ft12_pkg::PH_S_ADDR;
        ft12_pkg::PH_S_ADDR: begin
          if (count_inc >= {6'b0, nab}) begin
            phase_next = ft12_pkg::PH_S_SUM;
          end
        end
        ft12_pkg::PH_S_SUM:   phase_next = ft12_pkg::PH_S_END;
        ft12_pkg::PH_S_END:   phase_next = ft12_pkg::PH_HUNT;
        ft12_pkg::PH_L_LEN1:  phase_next = ft12_pkg::PH_L_LEN2;
        ft12_pkg::PH_L_LEN2: begin
          phase_next = (b != frame_length) ? hunt_phase : ft12_pkg::PH_L_START;
        end
        ft12_pkg::PH_L_START: begin
          if (b != ft12_pkg::START_LONG) begin
            phase_next = hunt_phase;
          end else if (too_short) begin
            phase_next = ft12_pkg::PH_HUNT;
          end else begin
            phase_next = ft12_pkg::PH_L_CTRL;
          end
        end
        ft12_pkg::PH_L_CTRL:  phase_next = ft12_pkg::PH_L_ADDR;
        ft12_pkg::PH_L_ADDR: begin
          if (count_inc >= {5'b0, nab_plus1}) begin
            phase_next = (count_inc >= frame_length) ? ft12_pkg::PH_L_SUM
                                                     : ft12_pkg::PH_L_DATA;
          end
        end
        ft12_pkg::PH_L_DATA: begin
          if (count_inc >= frame_length) begin
            phase_next = ft12_pkg::PH_L_SUM;
          end
        end
        ft12_pkg::PH_L_SUM:   phase_next = ft12_pkg::PH_L_END;
        ft12_pkg::PH_L_END:   phase_next = ft12_pkg::PH_HUNT;
        default:              phase_next = ft12_pkg::PH_HUNT;
      endcase
    end
  end

  // result for the current beat
  always_comb begin
    res_emit = 1'b0;
    res      = '0;
    if (is_idle) begin
      res_emit = (phase != ft12_pkg::PH_HUNT);
      res.kind = ft12_pkg::KIND_FRAME_ERR;
    end else begin
      unique case (phase)
        ft12_pkg::PH_HUNT: begin
          if (b == ft12_pkg::SINGLE_ACK) begin
            res_emit = 1'b1;
            res.kind = ft12_pkg::KIND_SINGLE;
          end
        end
        ft12_pkg::PH_L_LEN2: begin
          if (b != frame_length && b == ft12_pkg::SINGLE_ACK) begin
            res_emit = 1'b1;
            res.kind = ft12_pkg::KIND_SINGLE;
          end
        end
        ft12_pkg::PH_L_START: begin
          if (b != ft12_pkg::START_LONG) begin
            if (b == ft12_pkg::SINGLE_ACK) begin
              res_emit = 1'b1;
              res.kind = ft12_pkg::KIND_SINGLE;
            end
          end else if (too_short) begin
            res_emit = 1'b1;
            res.kind = ft12_pkg::KIND_FRAME_ERR;
          end
        end
        ft12_pkg::PH_L_DATA: begin
          res_emit      = 1'b1;
          res.kind      = ft12_pkg::KIND_DATA;
          res.data_byte = b;
        end
        ft12_pkg::PH_S_END: begin
          res_emit = 1'b1;
          if (b != ft12_pkg::END_BYTE) begin
            res.kind = ft12_pkg::KIND_FRAME_ERR;
          end else begin
            res = closing(running_sum, address_value, station_address, control_byte,
                          ft12_pkg::KIND_SHORT_OK, 8'd0);
          end
        end
        ft12_pkg::PH_L_END: begin
          res_emit = 1'b1;
          if (b != ft12_pkg::END_BYTE) begin
            res.kind = ft12_pkg::KIND_FRAME_ERR;
          end else begin
            res = closing(running_sum, address_value, station_address, control_byte,
                          ft12_pkg::KIND_LONG_OK, long_ulen);
          end
        end
        default: begin
          res_emit = 1'b0;
        end
      endcase
    end
  end

  // datapath registers
  always_comb begin
    frame_length_next  = frame_length;
    byte_count_next    = byte_count;
    running_sum_next   = running_sum;
    control_byte_next  = control_byte;
    address_value_next = address_value;
    if (!is_idle) begin
      unique case (phase) inside
        ft12_pkg::PH_S_CTRL, ft12_pkg::PH_L_CTRL: begin
          control_byte_next  = b;
          running_sum_next   = b;
          address_value_next = 16'h0000;
          byte_count_next    = (phase == ft12_pkg::PH_L_CTRL) ? 8'd1 : 8'd0;
        end
        ft12_pkg::PH_S_ADDR: begin
          address_value_next = address_value |
                               (byte_count[0] ? {b, 8'h00} : {8'h00, b});
          running_sum_next   = running_sum + b;
          byte_count_next    = count_inc;
        end
        ft12_pkg::PH_L_ADDR: begin
          // long frame count starts at one, so the octet select is inverted
          address_value_next = address_value |
                               (byte_count[0] ? {8'h00, b} : {b, 8'h00});
          running_sum_next   = running_sum + b;
          byte_count_next    = count_inc;
        end
        ft12_pkg::PH_L_DATA: begin
          running_sum_next = running_sum + b;
          byte_count_next  = count_inc;
        end
        ft12_pkg::PH_S_SUM, ft12_pkg::PH_L_SUM: begin
          running_sum_next = running_sum - b;
        end
        ft12_pkg::PH_L_LEN1: begin
          frame_length_next = b;
        end
        default: begin
          frame_length_next = frame_length;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ft12_pkg::PH_HUNT;
      frame_length  <= 8'd0;
      byte_count    <= 8'd0;
      running_sum   <= 8'd0;
      control_byte  <= 8'd0;
      address_value <= 16'h0000;
    end else if (advance) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      byte_count    <= byte_count_next;
      running_sum   <= running_sum_next;
      control_byte  <= control_byte_next;
      address_value <= address_value_next;
    end
  end

endmodule

FILE: rtl/ft12_out_stage.sv
// ----------------------------------------------------------------------------
// FT1.2 output stage
// Result register that holds one beat until the consumer takes it.
// ----------------------------------------------------------------------------
module ft12_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ft12_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        kind,
  output logic [7:0]        data_byte,
  output logic              dir_bit,
  output logic              prm_bit,
  output logic              fcb_bit,
  output logic              fcv_bit,
  output logic [3:0]        func_code,
  output logic [7:0]        user_length
);

  logic              full;
  ft12_pkg::result_t res_q;

  assign out_free    = !full || out_ready;
  assign out_valid   = full;
  assign kind        = res_q.kind;
  assign data_byte   = res_q.data_byte;
  assign dir_bit     = res_q.ctrl[7];
  assign prm_bit     = res_q.ctrl[6];
  assign fcb_bit     = res_q.ctrl[5];
  assign fcv_bit     = res_q.ctrl[4];
  assign func_code   = res_q.ctrl[3:0] & ft12_pkg::FUNC_MASK;
  assign user_length = res_q.user_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

FILE: rtl/ft12_frame_receiver.sv
// ----------------------------------------------------------------------------
// FT1.2 frame receiver
// Recognizes single-character, short and long FT1.2 link frames.
// ----------------------------------------------------------------------------
// Link bytes (op 0) or idle timeouts (op 1) enter one beat per cycle; each
// beat passes an input register, the frame parser and a result register, and
// a new beat can be taken every cycle, unless intake stalls. Intake stalls
// only while a result is waiting in the output register and the next beat
// also produces one. Each user-data byte of a long frame is delivered as a
// data beat, and a frame closes with one status beat. Registers: index 0 is
// the station address, index 1 the address octet count (bit 1 set selects
// two octets); write them only while idle.
module ft12_frame_receiver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ft12_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ft12_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         kind,
  output logic [7:0]                         data_byte,
  output logic                               dir_bit,
  output logic                               prm_bit,
  output logic                               fcb_bit,
  output logic                               fcv_bit,
  output logic [3:0]                         func_code,
  output logic [7:0]                         user_length
);

  logic [15:0]       station_address;
  logic [1:0]        address_bytes;
  logic              item_valid;
  ft12_pkg::item_t   item;
  logic              res_emit;
  ft12_pkg::result_t res;
  logic              out_free;
  logic              advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= ft12_pkg::STATION_ADDR_RST;
      address_bytes   <= ft12_pkg::ADDR_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ft12_pkg::REG_STATION_ADDR: station_address <= cfg_data;
        ft12_pkg::REG_ADDR_BYTES:   address_bytes   <= cfg_data[1:0];
        default:                    station_address <= station_address;
      endcase
    end
  end

  // a beat with no result never waits on the output register
  assign advance = item_valid && (!res_emit || out_free);

  ft12_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ft12_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .item            (item),
    .advance         (advance),
    .station_address (station_address),
    .address_bytes   (address_bytes),
    .res_emit        (res_emit),
    .res             (res)
  );

  ft12_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && res_emit),
    .res         (res),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data_byte   (data_byte),
    .dir_bit     (dir_bit),
    .prm_bit     (prm_bit),
    .fcb_bit     (fcb_bit),
    .fcv_bit     (fcv_bit),
    .func_code   (func_code),
    .user_length (user_length)
  );

`include "ft12_frame_receiver_assert.svh"

  // intake only stalls behind a result that is held up downstream
  `FT12_ASSERT_IMP(a_stall_cause, clk, rst, !in_ready,
                   item_valid && res_emit && out_valid && !out_ready)
  `FT12_ASSERT_NXT(a_beat_held, clk, rst, in_valid && in_ready, item_valid)
  `FT12_ASSERT_IMP(a_data_clean, clk, rst, out_valid && kind == ft12_pkg::KIND_DATA,
                   !dir_bit && !prm_bit && !fcb_bit && !fcv_bit &&
                   func_code == 4'd0 && user_length == 8'd0)
  `FT12_ASSERT_IMP(a_status_clean, clk, rst,
                   out_valid && kind != ft12_pkg::KIND_DATA, data_byte == 8'd0)

endmodule
